FILE: hdl/gn2d_pkg.sv
package gn2d_pkg;

   localparam int TABLE_DEPTH   = 512;
   localparam int IDX_W         = $clog2(TABLE_DEPTH);
   localparam int TBL_IDX_W     = 9;
   localparam int FRAC          = 16;
   localparam int GRAD_W        = 16;
   localparam int COORD_W       = 32;
   localparam int NOISE_W       = 18;
   localparam int INNER_FRAC    = 20;
   localparam int DOT_SHIFT     = FRAC + 14 - INNER_FRAC;
   localparam int DOT_W         = 24;
   localparam int NX_W          = DOT_W + 1;
   localparam int NY_W          = NX_W + 1;
   localparam int RND_SHIFT     = INNER_FRAC - 16;
   localparam int W_W           = FRAC + 1;
   localparam int T_W           = FRAC + 2;
   localparam logic [31:0] HASH_MUL_X = 32'd7385451;
   localparam logic [31:0] HASH_MUL_Y = 32'd19349663;
   localparam logic signed [NOISE_W-1:0] NOISE_MAX = {1'b0, {(NOISE_W-1){1'b1}}};
   localparam logic signed [NOISE_W-1:0] NOISE_MIN = {1'b1, {(NOISE_W-1){1'b0}}};

   typedef enum logic {OP_LOAD = 1'b0, OP_EVAL = 1'b1} op_type;

   typedef struct packed {
      logic                       valid;
      op_type                     op;
      logic [3:0][IDX_W-1:0]      addr;
      logic [IDX_W-1:0]           wr_idx;
      logic                       wr_ok;
      logic [2*GRAD_W-1:0]        wr_data;
      logic [FRAC-1:0]            sx;
      logic [FRAC-1:0]            sy;
      logic [FRAC-1:0]            s2x;
      logic [FRAC-1:0]            s2y;
   } front_type;

   function automatic logic [IDX_W-1:0] hash_idx(input logic [IDX_W-1:0] cx,
                                                 input logic [IDX_W-1:0] cy);
      logic [2*IDX_W-1:0] hx;
      logic [2*IDX_W-1:0] hy;
      hx = cx * HASH_MUL_X[IDX_W-1:0];
      hy = cy * HASH_MUL_Y[IDX_W-1:0];
      return hx[IDX_W-1:0] ^ hy[IDX_W-1:0];
   endfunction

endpackage

FILE: hdl/gn2d_req_if.sv
interface gn2d_req_if import gn2d_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      operation;
   logic [TBL_IDX_W-1:0]      table_index;
   logic signed [GRAD_W-1:0]  grad_x;
   logic signed [GRAD_W-1:0]  grad_y;
   logic signed [COORD_W-1:0] coord_x;
   logic signed [COORD_W-1:0] coord_y;

   modport source (output valid, operation, table_index, grad_x, grad_y, coord_x, coord_y,
                   input ready);
   modport sink (input valid, operation, table_index, grad_x, grad_y, coord_x, coord_y,
                 output ready);
endinterface

FILE: hdl/gn2d_rsp_if.sv
interface gn2d_rsp_if import gn2d_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [NOISE_W-1:0] noise_value;

   modport source (output valid, noise_value, input ready);
   modport sink (input valid, noise_value, output ready);
endinterface

FILE: hdl/gn2d_front.sv
module gn2d_front import gn2d_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  logic                      in_valid,
   input  logic                      operation,
   input  logic [TBL_IDX_W-1:0]      table_index,
   input  logic signed [GRAD_W-1:0]  grad_x,
   input  logic signed [GRAD_W-1:0]  grad_y,
   input  logic signed [COORD_W-1:0] coord_x,
   input  logic signed [COORD_W-1:0] coord_y,
   output front_type                 front
);

   front_type             front_ff;
   front_type             front_in;
   logic [IDX_W-1:0]      x0, y0, x1, y1;
   logic [2*FRAC-1:0]     sqx, sqy;

   always_comb begin
      x0 = coord_x[FRAC +: IDX_W];
      y0 = coord_y[FRAC +: IDX_W];
      x1 = x0 + IDX_W'(1);
      y1 = y0 + IDX_W'(1);
      sqx = coord_x[FRAC-1:0] * coord_x[FRAC-1:0];
      sqy = coord_y[FRAC-1:0] * coord_y[FRAC-1:0];
      front_in.valid   = in_valid;
      front_in.op      = op_type'(operation);
      front_in.addr[0] = hash_idx(x0, y0);
      front_in.addr[1] = hash_idx(x1, y0);
      front_in.addr[2] = hash_idx(x0, y1);
      front_in.addr[3] = hash_idx(x1, y1);
      front_in.wr_idx  = IDX_W'(table_index);
      front_in.wr_ok   = 32'(table_index) < TABLE_DEPTH;
      front_in.wr_data = {grad_y, grad_x};
      front_in.sx      = coord_x[FRAC-1:0];
      front_in.sy      = coord_y[FRAC-1:0];
      front_in.s2x     = sqx[2*FRAC-1:FRAC];
      front_in.s2y     = sqy[2*FRAC-1:FRAC];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff.valid <= 1'b0;
      end else if (adv) begin
         front_ff <= front_in;
      end
   end

   assign front = front_ff;

endmodule

FILE: hdl/gn2d_ram.sv
module gn2d_ram import gn2d_pkg::*; (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [IDX_W-1:0]        wr_addr,
   input  logic [2*GRAD_W-1:0]     wr_data,
   input  logic                    rd_en,
   input  logic [IDX_W-1:0]        rd_addr,
   output logic [2*GRAD_W-1:0]     rd_data
);

   logic [2*GRAD_W-1:0] mem [TABLE_DEPTH];
   logic [2*GRAD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/gn2d_back.sv
module gn2d_back import gn2d_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic [3:0][2*GRAD_W-1:0]      grad,
   input  logic [FRAC-1:0]               sx,
   input  logic [FRAC-1:0]               sy,
   input  logic [W_W-1:0]                wx,
   input  logic [W_W-1:0]                wy,
   output logic                          out_valid,
   output logic signed [NOISE_W-1:0]     noise
);

   logic                          v3_ff, v4_ff, v5_ff, v6_ff;
   logic signed [DOT_W-1:0]       n_ff [4];
   logic signed [DOT_W-1:0]       n_in [4];
   logic [W_W-1:0]                wx3_ff, wy3_ff, wy4_ff;
   logic signed [NX_W-1:0]        nx0_ff, nx1_ff, nx0_in, nx1_in;
   logic signed [NY_W-1:0]        r_ff, r_in;
   logic signed [NOISE_W-1:0]     noise_ff, noise_in;
   logic signed [FRAC:0]          dx [2];
   logic signed [FRAC:0]          dy [2];
   logic signed [FRAC+GRAD_W:0]   px [4];
   logic signed [FRAC+GRAD_W:0]   py [4];
   logic signed [FRAC+GRAD_W+1:0] dsum [4];
   logic signed [NX_W-1:0]        d0, d1;
   logic signed [NX_W+W_W:0]      p0, p1;
   logic signed [NY_W-1:0]        dr;
   logic signed [NY_W+W_W:0]      pr;
   logic signed [NY_W-1:0]        rnd;
   logic signed [NY_W-RND_SHIFT-1:0] rs;

   always_comb begin
      dx[0] = $signed({1'b0, sx});
      dx[1] = $signed({1'b1, sx});
      dy[0] = $signed({1'b0, sy});
      dy[1] = $signed({1'b1, sy});
      for (int k = 0; k < 4; k++) begin
         px[k]   = dx[k%2] * $signed(grad[k][GRAD_W-1:0]);
         py[k]   = dy[k/2] * $signed(grad[k][2*GRAD_W-1:GRAD_W]);
         dsum[k] = (FRAC+GRAD_W+2)'(px[k]) + (FRAC+GRAD_W+2)'(py[k]);
         n_in[k] = DOT_W'(dsum[k] >>> DOT_SHIFT);
      end
   end

   always_comb begin
      d0 = NX_W'(n_ff[1]) - NX_W'(n_ff[0]);
      d1 = NX_W'(n_ff[3]) - NX_W'(n_ff[2]);
      p0 = d0 * $signed({1'b0, wx3_ff});
      p1 = d1 * $signed({1'b0, wx3_ff});
      nx0_in = NX_W'(n_ff[0]) + NX_W'(p0 >>> FRAC);
      nx1_in = NX_W'(n_ff[2]) + NX_W'(p1 >>> FRAC);
   end

   always_comb begin
      dr   = NY_W'(nx1_ff) - NY_W'(nx0_ff);
      pr   = dr * $signed({1'b0, wy4_ff});
      r_in = NY_W'(nx0_ff) + NY_W'(pr >>> FRAC);
   end

   always_comb begin
      rnd = r_ff + NY_W'(8);
      rs  = (NY_W-RND_SHIFT)'(rnd >>> RND_SHIFT);
      if (rs > (NY_W-RND_SHIFT)'(NOISE_MAX)) begin
         noise_in = NOISE_MAX;
      end else if (rs < (NY_W-RND_SHIFT)'(NOISE_MIN)) begin
         noise_in = NOISE_MIN;
      end else begin
         noise_in = NOISE_W'(rs);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= in_valid;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
      if (adv) begin
         for (int k = 0; k < 4; k++) begin
            n_ff[k] <= n_in[k];
         end
         wx3_ff   <= wx;
         wy3_ff   <= wy;
         wy4_ff   <= wy3_ff;
         nx0_ff   <= nx0_in;
         nx1_ff   <= nx1_in;
         r_ff     <= r_in;
         noise_ff <= noise_in;
      end
   end

   assign out_valid = v6_ff;
   assign noise     = noise_ff;

endmodule

FILE: hdl/gradient_noise_2d.sv
// Channel   Dir  Payload                                              Handshake
// req_chan  in   operation table_index grad_x grad_y coord_x coord_y  valid/ready
// rsp_chan  out  noise_value                                          valid/ready
//
// One request per cycle unless rsp_chan stalls; the noise value is registered.
// A load request writes all four table copies and yields no response.
// Reset is synchronous and clears the stage valid bits; the table is not cleared.
// A stalled response freezes every stage, the table read ports included.
module gradient_noise_2d import gn2d_pkg::*; (
   input logic        clock,
   input logic        reset,
   gn2d_req_if.sink   req_chan,
   gn2d_rsp_if.source rsp_chan
);

   logic                       adv;
   front_type                  front;
   logic                       wr_en;
   logic [3:0][2*GRAD_W-1:0]   grad;
   logic                       v2_ff, v2_in;
   logic [FRAC-1:0]            sx2_ff, sy2_ff;
   logic [W_W-1:0]             wx2_ff, wy2_ff, wx2_in, wy2_in;
   logic [T_W-1:0]             tx, ty;
   logic [FRAC+T_W-1:0]        wpx, wpy;

   assign adv            = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = adv;

   gn2d_front u_front (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (req_chan.valid),
      .operation   (req_chan.operation),
      .table_index (req_chan.table_index),
      .grad_x      (req_chan.grad_x),
      .grad_y      (req_chan.grad_y),
      .coord_x     (req_chan.coord_x),
      .coord_y     (req_chan.coord_y),
      .front       (front)
   );

   assign wr_en = adv && front.valid && front.op == OP_LOAD && front.wr_ok;

   for (genvar k = 0; k < 4; k++) begin : g_ram
      gn2d_ram u_ram (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (front.wr_idx),
         .wr_data (front.wr_data),
         .rd_en   (adv),
         .rd_addr (front.addr[k]),
         .rd_data (grad[k])
      );
   end

   always_comb begin
      tx     = T_W'(3 << FRAC) - {1'b0, front.sx, 1'b0};
      ty     = T_W'(3 << FRAC) - {1'b0, front.sy, 1'b0};
      wpx    = front.s2x * tx;
      wpy    = front.s2y * ty;
      wx2_in = wpx[FRAC +: W_W];
      wy2_in = wpy[FRAC +: W_W];
      v2_in  = front.valid && front.op == OP_EVAL;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v2_in;
      end
      if (adv) begin
         sx2_ff <= front.sx;
         sy2_ff <= front.sy;
         wx2_ff <= wx2_in;
         wy2_ff <= wy2_in;
      end
   end

   gn2d_back u_back (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v2_ff),
      .grad      (grad),
      .sx        (sx2_ff),
      .sy        (sy2_ff),
      .wx        (wx2_ff),
      .wy        (wy2_ff),
      .out_valid (rsp_chan.valid),
      .noise     (rsp_chan.noise_value)
   );

   a_reset_clears: assert property (@(posedge clock) $past(reset) |-> !rsp_chan.valid)
      else $error("response valid after reset");
   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(v2_ff) && $stable(front.valid))
      else $error("stage moved during stall");
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      adv && front.valid && front.op == OP_LOAD |=> !v2_ff)
      else $error("load request entered evaluate path");
   a_no_write_stall: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> adv && front.op == OP_LOAD)
      else $error("table write outside an advancing load");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import gn2d_pkg::*;

   typedef struct {
      op_type                    op;
      logic [TBL_IDX_W-1:0]      idx;
      logic signed [GRAD_W-1:0]  gx;
      logic signed [GRAD_W-1:0]  gy;
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
   } request_type;

   localparam int RANDOM_REQUESTS = 323;
   localparam int CALM_TAIL       = 150;
   localparam int CYCLE_LIMIT     = 300000;

   logic clock;
   logic reset;

   gn2d_req_if req_chan ();
   gn2d_rsp_if rsp_chan ();

   gradient_noise_2d uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   request_type               pending_reqs[$];
   logic signed [NOISE_W-1:0] expected_noise[$];
   logic [31:0]               grad_table[TABLE_DEPTH];
   int                        total_reqs;
   int                        accepted_reqs;
   int                        accepted_evals;
   int                        errors;
   int                        send_gap;
   int                        recv_gap;
   int                        long_hold;
   bit                        long_hold_done;
   bit                        stimulus_ready;
   longint                    cycle_count;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic longint corner_dot(longint cx, longint cy, longint dx, longint dy);
      logic [31:0] ux;
      logic [31:0] uy;
      logic [31:0] h;
      logic [31:0] entry;
      longint      gx;
      longint      gy;
      ux = cx[31:0];
      uy = cy[31:0];
      h = (ux * HASH_MUL_X) ^ (uy * HASH_MUL_Y);
      entry = grad_table[h[IDX_W-1:0]];
      gx = longint'($signed(entry[15:0]));
      gy = longint'($signed(entry[31:16]));
      return (dx * gx + dy * gy) >>> DOT_SHIFT;
   endfunction

   function automatic longint smooth_weight(longint s);
      longint s2;
      longint t;
      s2 = (s * s) >>> FRAC;
      t = 3 * (longint'(1) << FRAC) - 2 * s;
      return (s2 * t) >>> FRAC;
   endfunction

   function automatic longint lerp_q20(longint a, longint b, longint w);
      return a + (((b - a) * w) >>> FRAC);
   endfunction

   function automatic logic signed [NOISE_W-1:0] noise_at(logic signed [31:0] px,
                                                          logic signed [31:0] py);
      longint one;
      longint sx;
      longint sy;
      longint x0;
      longint y0;
      longint wx;
      longint wy;
      longint r;
      one = longint'(1) << FRAC;
      sx = longint'(px[FRAC-1:0]);
      sy = longint'(py[FRAC-1:0]);
      x0 = longint'(px) >>> FRAC;
      y0 = longint'(py) >>> FRAC;
      wx = smooth_weight(sx);
      wy = smooth_weight(sy);
      r = lerp_q20(lerp_q20(corner_dot(x0, y0, sx, sy),
                            corner_dot(x0 + 1, y0, sx - one, sy), wx),
                   lerp_q20(corner_dot(x0, y0 + 1, sx, sy - one),
                            corner_dot(x0 + 1, y0 + 1, sx - one, sy - one), wx),
                   wy);
      r = (r + 8) >>> RND_SHIFT;
      if (r > longint'(NOISE_MAX)) r = longint'(NOISE_MAX);
      if (r < longint'(NOISE_MIN)) r = longint'(NOISE_MIN);
      return r[NOISE_W-1:0];
   endfunction

   function automatic request_type load_req(int idx, int gx, int gy);
      request_type r;
      r.op = OP_LOAD;
      r.idx = idx[TBL_IDX_W-1:0];
      r.gx = gx[GRAD_W-1:0];
      r.gy = gy[GRAD_W-1:0];
      r.cx = $urandom;
      r.cy = $urandom;
      return r;
   endfunction

   function automatic request_type eval_req(logic [31:0] cx, logic [31:0] cy);
      request_type r;
      r.op = OP_EVAL;
      r.idx = TBL_IDX_W'($urandom);
      r.gx = GRAD_W'($urandom);
      r.gy = GRAD_W'($urandom);
      r.cx = cx;
      r.cy = cy;
      return r;
   endfunction

   function automatic logic [31:0] random_coord();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return {{16{1'b0}}, 16'($urandom_range(0, 65535))} + ($urandom_range(0, 40) << 16);
         2: return -($urandom_range(0, 40) << 16) - $urandom_range(0, 65535);
         default: return {$urandom_range(0, 1) ? 16'h7FFF : 16'h8000, 16'($urandom)};
      endcase
   endfunction

   initial begin
      int gx;
      int gy;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         case (i)
            0: begin gx = 16384; gy = -16384; end
            1: begin gx = -32768; gy = 32767; end
            2: begin gx = 32767; gy = 32767; end
            3: begin gx = -32768; gy = -32768; end
            4: begin gx = 0; gy = 0; end
            5: begin gx = -16384; gy = 16384; end
            default: begin gx = $urandom_range(0, 65535); gy = $urandom_range(0, 65535); end
         endcase
         pending_reqs.push_back(load_req(i, gx, gy));
      end
      pending_reqs.push_back(eval_req(32'h0000_0000, 32'h0000_0000));
      pending_reqs.push_back(eval_req(32'h7FFF_FFFF, 32'h7FFF_FFFF));
      pending_reqs.push_back(eval_req(32'h8000_0000, 32'h8000_0000));
      pending_reqs.push_back(eval_req(32'h7FFF_FFFF, 32'h8000_0000));
      pending_reqs.push_back(eval_req(32'h8000_0000, 32'h7FFF_FFFF));
      pending_reqs.push_back(eval_req(32'hFFFF_FFFF, 32'h0000_0000));
      pending_reqs.push_back(eval_req(32'h0000_FFFF, 32'hFFFF_0000));
      pending_reqs.push_back(eval_req(32'h0000_8000, 32'h0000_8000));
      pending_reqs.push_back(eval_req(32'h0003_0000, 32'hFFFD_0000));
      pending_reqs.push_back(eval_req(32'h7FFF_0000, 32'h8000_FFFF));
      pending_reqs.push_back(eval_req(32'h0000_7FFF, 32'h0001_8001));
      pending_reqs.push_back(load_req(511, 32767, -32768));
      pending_reqs.push_back(load_req(0, 32767, 32767));
      pending_reqs.push_back(eval_req(32'h0000_8000, 32'hFFFF_8000));
      pending_reqs.push_back(eval_req(32'hFFFF_7FFF, 32'h0000_C000));
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         if ($urandom_range(0, 9) < 3)
            pending_reqs.push_back(load_req($urandom_range(0, 511),
                                            $urandom_range(0, 65535), $urandom_range(0, 65535)));
         else
            pending_reqs.push_back(eval_req(random_coord(), random_coord()));
      end
      total_reqs = pending_reqs.size();
      stimulus_ready = 1'b1;
   end

   initial begin
      reset = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      request_type r;
      bit          fire;
      bit          calm;
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.operation <= 1'b0;
         req_chan.table_index <= '0;
         req_chan.grad_x <= '0;
         req_chan.grad_y <= '0;
         req_chan.coord_x <= '0;
         req_chan.coord_y <= '0;
         send_gap = 0;
         accepted_reqs = 0;
      end else begin
         fire = req_chan.valid && req_chan.ready;
         if (fire) begin
            accepted_reqs++;
            if (req_chan.operation == OP_LOAD) begin
               grad_table[req_chan.table_index] = {req_chan.grad_y, req_chan.grad_x};
            end else begin
               expected_noise.push_back(noise_at(req_chan.coord_x, req_chan.coord_y));
            end
         end
         if (!req_chan.valid || fire) begin
            calm = accepted_reqs >= total_reqs - CALM_TAIL;
            if (send_gap > 0) begin
               send_gap--;
               req_chan.valid <= 1'b0;
            end else if (stimulus_ready && pending_reqs.size() > 0) begin
               r = pending_reqs.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.operation <= r.op;
               req_chan.table_index <= r.idx;
               req_chan.grad_x <= r.gx;
               req_chan.grad_y <= r.gy;
               req_chan.coord_x <= r.cx;
               req_chan.coord_y <= r.cy;
               if (!calm && $urandom_range(0, 9) == 0)
                  send_gap = $urandom_range(1, 14);
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      bit calm;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         recv_gap = 0;
         long_hold = 0;
         long_hold_done = 1'b0;
         accepted_evals = 0;
         errors = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            accepted_evals++;
            if (expected_noise.size() == 0) begin
               $display("%0t: unexpected response, expected none actual %0d",
                        $time, rsp_chan.noise_value);
               errors++;
            end else begin
               logic signed [NOISE_W-1:0] want;
               want = expected_noise.pop_front();
               if (rsp_chan.noise_value !== want) begin
                  $display("%0t: noise_value mismatch, expected %0d actual %0d",
                           $time, want, rsp_chan.noise_value);
                  errors++;
               end
            end
         end
         calm = accepted_reqs >= total_reqs - CALM_TAIL;
         if (!long_hold_done && accepted_evals >= 200) begin
            long_hold_done = 1'b1;
            long_hold = 300;
         end
         if (long_hold > 0) begin
            long_hold--;
            rsp_chan.ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            if (!calm && $urandom_range(0, 9) == 0)
               recv_gap = $urandom_range(1, 14);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         cycle_count <= 0;
      end else begin
         cycle_count <= cycle_count + 1;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      @(negedge reset);
      do @(posedge clock);
      while (!stimulus_ready || pending_reqs.size() > 0 || req_chan.valid
             || expected_noise.size() > 0);
      repeat (20) @(posedge clock);
      if (expected_noise.size() > 0) begin
         $display("%0t: %0d responses missing", $time, expected_noise.size());
         errors++;
      end
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
